// File: sv/tmba_pkg.sv
package tmba_pkg;

   typedef enum logic [1:0] {
      FMT_ARGB1555 = 2'd0,
      FMT_ARGB4444 = 2'd1,
      FMT_RGB565   = 2'd2,
      FMT_PAL8     = 2'd3
   } texel_format_type;

   localparam int TexelWidth = 16;
   localparam int ChanWidth  = 6;
   localparam int SumWidth   = 8;
   localparam int IndexWidth = 8;

   typedef struct packed {
      logic [TexelWidth-1:0] texel;
      logic                  level_start;
   } item_type;

   typedef struct packed {
      logic [ChanWidth-1:0] a;
      logic [ChanWidth-1:0] r;
      logic [ChanWidth-1:0] g;
      logic [ChanWidth-1:0] b;
   } chan_type;

   typedef struct packed {
      logic [SumWidth-1:0] a;
      logic [SumWidth-1:0] r;
      logic [SumWidth-1:0] g;
      logic [SumWidth-1:0] b;
   } sums_type;

   function automatic chan_type split_channels(texel_format_type fmt,
                                               logic [TexelWidth-1:0] v);
      chan_type c;
      c = '0;
      case (fmt)
         FMT_ARGB1555: begin
            c.a = {5'd0, v[15]};
            c.r = {1'b0, v[14:10]};
            c.g = {1'b0, v[9:5]};
            c.b = {1'b0, v[4:0]};
         end
         FMT_ARGB4444: begin
            c.a = {2'd0, v[15:12]};
            c.r = {2'd0, v[11:8]};
            c.g = {2'd0, v[7:4]};
            c.b = {2'd0, v[3:0]};
         end
         FMT_RGB565: begin
            c.r = {1'b0, v[15:11]};
            c.g = v[10:5];
            c.b = {1'b0, v[4:0]};
         end
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [TexelWidth-1:0] pack_average(texel_format_type fmt,
                                                          sums_type s,
                                                          logic [IndexWidth-1:0] idx);
      logic [SumWidth-3:0] a;
      logic [SumWidth-3:0] r;
      logic [SumWidth-3:0] g;
      logic [SumWidth-3:0] b;
      logic [TexelWidth-1:0] p;
      a = s.a[SumWidth-1:2];
      r = s.r[SumWidth-1:2];
      g = s.g[SumWidth-1:2];
      b = s.b[SumWidth-1:2];
      case (fmt)
         FMT_ARGB1555: p = {a[0], r[4:0], g[4:0], b[4:0]};
         FMT_ARGB4444: p = {a[3:0], r[3:0], g[3:0], b[3:0]};
         FMT_RGB565:   p = {r[4:0], g[5:0], b[4:0]};
         FMT_PAL8:     p = {8'd0, idx};
         default:      p = '0;
      endcase
      return p;
   endfunction

endpackage

// File: sv/tmba_quad_accum.sv
module tmba_quad_accum
   import tmba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  item_type              item,
   input  texel_format_type      fmt,
   output logic                  emit,
   output logic [TexelWidth-1:0] result
);

   logic [1:0]            phase_ff;
   logic [1:0]            phase_in;
   logic [1:0]            phase_eff;
   sums_type              sums_ff;
   sums_type              sums_in;
   sums_type              sums_base;
   logic [IndexWidth-1:0] first_ff;
   logic [IndexWidth-1:0] first_in;
   chan_type              chan;

   // emit flags an item that closes a quad; it does not depend on step
   always_comb begin
      phase_eff = item.level_start ? 2'd0 : phase_ff;
      chan      = split_channels(fmt, item.texel);
      sums_base = (phase_eff == 2'd0) ? '0 : sums_ff;
      first_in  = (phase_eff == 2'd0) ? item.texel[IndexWidth-1:0] : first_ff;
      sums_in.a = sums_base.a + SumWidth'(chan.a);
      sums_in.r = sums_base.r + SumWidth'(chan.r);
      sums_in.g = sums_base.g + SumWidth'(chan.g);
      sums_in.b = sums_base.b + SumWidth'(chan.b);
      phase_in  = phase_eff + 2'd1;
      emit      = (phase_eff == 2'd3);
      result    = pack_average(fmt, sums_in, first_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         sums_ff  <= '0;
         first_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         sums_ff  <= sums_in;
         first_ff <= first_in;
      end
   end

   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> phase_ff == 2'd0)
      else $error("quad phase did not wrap after a result");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(first_ff))
      else $error("quad state moved without an item");

   a_phase_adv: assert property (@(posedge clock) disable iff (reset)
      step && !item.level_start && phase_ff == 2'd1 |=> phase_ff == 2'd2)
      else $error("quad phase did not advance");

   a_pal_high: assert property (@(posedge clock) disable iff (reset)
      step && emit && fmt == FMT_PAL8 |-> result[TexelWidth-1:IndexWidth] == '0)
      else $error("paletted result has nonzero high byte");

endmodule

// File: sv/tmba_out_reg.sv
module tmba_out_reg
   import tmba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [TexelWidth-1:0] data,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TexelWidth-1:0] rsp_averaged_texel
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [TexelWidth-1:0] data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_averaged_texel = data_ff;

endmodule

// File: sv/twiddled_mipmap_box_average.sv
// 2x2 box-filter mipmap reducer for twiddled textures. Texels of one level
// stream in, four consecutive texels forming a quad; on the fourth the block
// emits one texel of the next level, each channel the quad sum divided by four
// and truncated (ARGB1555 alpha set only if all four are set, paletted mode
// passes the quad's first index). level_start restarts grouping and drops a
// partial quad. One item per cycle is accepted; req_ready drops only while the
// input register holds the fourth texel of a quad and an unread result still
// sits in the result register. A quad's result enters the result register as
// its fourth texel leaves the input register, raising rsp_valid. Write
// csr_write_data (format) only while no items are in flight.
module twiddled_mipmap_box_average
   import tmba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TexelWidth-1:0] req_texel,
   input  logic                  req_level_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TexelWidth-1:0] rsp_averaged_texel
);

   texel_format_type      format_ff;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   item_type              in_item_ff;
   logic                  advance;
   logic                  emit;
   logic                  out_load;
   logic                  out_free;
   logic [TexelWidth-1:0] result;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_ARGB1555;
      end else if (csr_write_enable) begin
         format_ff <= texel_format_type'(csr_write_data);
      end
   end

   // an item with no result always moves on; one with a result waits for room
   assign advance     = in_valid_ff && (!emit || out_free);
   assign out_load    = advance && emit;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.texel       <= req_texel;
         in_item_ff.level_start <= req_level_start;
      end
   end

   tmba_quad_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .fmt    (format_ff),
      .emit   (emit),
      .result (result)
   );

   tmba_out_reg u_out (
      .clock              (clock),
      .reset              (reset),
      .load               (out_load),
      .data               (result),
      .free               (out_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_averaged_texel (rsp_averaged_texel)
   );

endmodule
